// File: rtl/lidar_polar_to_cartesian_assert.svh
// Assertion macros used by the converter's top-level RTL file.
`ifndef LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPC_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/lpc_pkg.sv
// Types, constants and divisor tables of the lidar polar-to-Cartesian converter.
package lpc_pkg;

  localparam int RANGE_BITS_DEF = 16;
  localparam int LINE_BITS_DEF  = 20;

  // Serial arithmetic unit geometry.
  localparam int MUL_B_BITS  = 32;
  localparam int DIV_BITS    = 37;
  localparam int DVS_BITS    = 10;
  localparam int TWO_PI_BITS = 39;

  localparam logic [TWO_PI_BITS-1:0] TWO_PI_Q36   = 39'h64_87ED_5111;
  localparam logic [30:0]            Q30_ONE      = 31'h4000_0000;
  localparam logic [24:0]            COORD_MAX    = 25'h0FF_FFFF;
  localparam logic [DVS_BITS-1:0]    TIME_DIVISOR = 10'd1000;
  localparam logic [DVS_BITS-1:0]    TIME_ROUND   = 10'd500;

  localparam int SIN_TERMS = 5;
  localparam int COS_TERMS = 6;

  // Configuration reset values.
  localparam logic        MODE_RST       = 1'b0;
  localparam logic [23:0] ANGLE_STEP_RST = 24'd11651;
  localparam logic [19:0] LINE_PERIOD_RST = 20'd25000;
  localparam logic [19:0] STEP_TIME_RST  = 20'd17361;

  typedef enum logic [1:0] {
    CFG_MODE,
    CFG_ANGLE_STEP,
    CFG_LINE_PERIOD,
    CFG_STEP_TIME
  } lpc_cfg_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } lpc_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANGLE,
    S_XR,
    S_X2,
    S_SIN_MUL,
    S_SIN_DIV,
    S_SIN_END,
    S_COS_MUL,
    S_COS_DIV,
    S_X,
    S_Y,
    S_LINE,
    S_STEP,
    S_TIME,
    S_FINISH
  } lpc_state_t;

  typedef struct packed {
    logic    start;
    lpc_op_t op;
  } lpc_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpc_sts_t;

  // Horner divisors of the sine series, outermost term first.
  function automatic logic [DVS_BITS-1:0] sin_div(input logic [2:0] k);
    logic [DVS_BITS-1:0] d;
    case (k)
      3'd0:    d = 10'd110;
      3'd1:    d = 10'd72;
      3'd2:    d = 10'd42;
      3'd3:    d = 10'd20;
      default: d = 10'd6;
    endcase
    return d;
  endfunction

  // Horner divisors of the cosine series, outermost term first.
  function automatic logic [DVS_BITS-1:0] cos_div(input logic [2:0] k);
    logic [DVS_BITS-1:0] d;
    case (k)
      3'd0:    d = 10'd132;
      3'd1:    d = 10'd90;
      3'd2:    d = 10'd56;
      3'd3:    d = 10'd30;
      3'd4:    d = 10'd12;
      default: d = 10'd2;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/lpc_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider by a small divisor.
module lpc_serial_unit import lpc_pkg::*; #(
  parameter int A_BITS = TWO_PI_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lpc_ctl_t                       ctl,
  input  logic [A_BITS-1:0]              opa,
  input  logic [MUL_B_BITS-1:0]          opb,
  output lpc_sts_t                       sts,
  output logic [A_BITS+MUL_B_BITS-1:0]   res
);

  localparam int P_BITS   = A_BITS + MUL_B_BITS;
  localparam int CNT_BITS = $clog2(((MUL_B_BITS > DIV_BITS) ? MUL_B_BITS : DIV_BITS) + 1);

  logic [P_BITS-1:0]   prod;
  logic [A_BITS-1:0]   mcand;
  logic [DVS_BITS-1:0] rem;
  logic [CNT_BITS-1:0] cnt;
  lpc_op_t             op_r;
  logic                busy;
  logic                done;

  logic [A_BITS:0]     mul_sum;
  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   rem_sub;
  logic                div_ge;

  // Multiplication: the multiplier sits in the low bits and leaves one bit per
  // cycle while the partial sum enters from the top.
  always_comb begin
    mul_sum = {1'b0, prod[P_BITS-1:MUL_B_BITS]} + (prod[0] ? {1'b0, mcand} : '0);
    rem_sh  = {rem, prod[DIV_BITS-1]};
    div_ge  = (rem_sh >= {1'b0, mcand[DVS_BITS-1:0]});
    rem_sub = rem_sh - {1'b0, mcand[DVS_BITS-1:0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op_r <= ctl.op;
      rem  <= '0;
      if (ctl.op == OP_MUL) begin
        mcand <= opa;
        prod  <= P_BITS'(opb);
      end else begin
        mcand <= A_BITS'(opb[DVS_BITS-1:0]);
        prod  <= P_BITS'(opa[DIV_BITS-1:0]);
      end
    end else if (busy) begin
      if (op_r == OP_MUL) begin
        prod <= {mul_sum, prod[MUL_B_BITS-1:1]};
      end else begin
        // Quotient bits fill the dividend register from the bottom.
        prod[DIV_BITS-1:0] <= {prod[DIV_BITS-2:0], div_ge};
        rem                <= div_ge ? rem_sub[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= (ctl.op == OP_MUL) ? CNT_BITS'(MUL_B_BITS) : CNT_BITS'(DIV_BITS);
    end else begin
      done <= busy && (cnt == CNT_BITS'(1));
      if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign res      = prod;

endmodule

// File: rtl/lidar_polar_to_cartesian.sv
// Lidar polar-to-Cartesian converter: one range sample in, at most one point out.
// The sample channel (sample_valid/sample_ready) takes step_index, range_mm,
// intensity_in and line_start; the point channel (point_valid/point_ready) gives
// x_q8, y_q8, angle_turns, time_us, line_number and intensity_out.
// Registers are written through cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high; the user must make writes only while the block is
// idle, since the block itself does not enforce it. A sample that yields a point
// goes through one shared bit-serial unit: 19 multiplications and 12 divisions
// by small constants. No new sample is taken until the point has left the last
// step. A mode 0 sample with no echo gives no point, and the block stays ready
// for the next sample.
// Reset restores the register defaults, clears the line and step counters and
// empties the point channel.
// A finished point waits in the output register while the receiver stalls; the
// next sample is accepted meanwhile, and should its point finish before the first
// is taken, the block holds it in its last step until the output register frees.
`include "lidar_polar_to_cartesian_assert.svh"

module lidar_polar_to_cartesian import lpc_pkg::*; #(
  parameter int RANGE_BITS = RANGE_BITS_DEF,
  parameter int LINE_BITS  = LINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  logic [15:0]        step_index,
  input  logic [15:0]        range_mm,
  input  logic [15:0]        intensity_in,
  input  logic               line_start,
  output logic               point_valid,
  input  logic               point_ready,
  output logic signed [24:0] x_q8,
  output logic signed [24:0] y_q8,
  output logic [23:0]        angle_turns,
  output logic [47:0]        time_us,
  output logic [19:0]        line_number,
  output logic [15:0]        intensity_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int A_BITS = (LINE_BITS > TWO_PI_BITS) ? LINE_BITS : TWO_PI_BITS;
  localparam int P_BITS = A_BITS + MUL_B_BITS;
  localparam logic [15:0] RANGE_MASK =
    (RANGE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RANGE_BITS) - 32'd1);

  // Configuration and control state.
  logic                 mode;
  logic [23:0]          angle_step;
  logic [19:0]          line_period;
  logic [19:0]          step_time;
  logic [LINE_BITS-1:0] line_counter;
  logic [15:0]          previous_step;
  logic [15:0]          step_counter;
  logic                 seen_first;
  lpc_state_t           state;
  lpc_state_t           state_next;
  logic                 issued;
  logic                 issued_next;
  logic [2:0]           k;

  // Working registers.
  logic [15:0] step_r;
  logic [15:0] range_r;
  logic [15:0] inten_r;
  logic [23:0] angle;
  logic [29:0] xr;
  logic [29:0] x2;
  logic [30:0] t;
  logic [30:0] s;
  logic [24:0] xq;
  logic [24:0] yq;
  logic [47:0] lp;
  logic [36:0] num;
  logic [47:0] timev;

  lpc_ctl_t              ctl;
  lpc_sts_t              sts;
  logic [A_BITS-1:0]     opa;
  logic [MUL_B_BITS-1:0] opb;
  logic [P_BITS-1:0]     res;

  logic                 accept;
  logic                 has_result;
  logic                 op_done;
  logic                 out_load;
  logic                 calc;
  lpc_state_t           after;
  logic [15:0]          range_eff;
  logic [15:0]          step_sel;
  logic [2:0]           oct;
  logic                 swap;
  logic                 cneg;
  logic                 sneg;
  logic [21:0]          r_fold;
  logic [30:0]          cmag;
  logic [30:0]          smag;
  logic [LINE_BITS+19:0] line_ext;

  // Rounds a Q30 product down to Q8, saturates and applies the octant sign.
  function automatic logic [24:0] to_coord(input logic [P_BITS-1:0] p, input logic neg);
    logic [32:0] mag;
    logic [24:0] sat;
    mag = p[54:22] + {32'd0, p[21]};
    sat = (mag > 33'(COORD_MAX)) ? COORD_MAX : mag[24:0];
    return neg ? (25'd0 - sat) : sat;
  endfunction

  assign sample_ready = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign accept       = sample_valid && sample_ready;
  assign range_eff    = range_mm & RANGE_MASK;
  assign has_result   = mode || (range_eff > 16'd1);
  assign step_sel     = mode ? step_index :
                        ((!seen_first || line_start) ? 16'd0 : step_counter);
  assign op_done      = issued && sts.done;
  assign out_load     = (state == S_FINISH) && (!point_valid || point_ready);

  // Octant symmetry: the remainder is mirrored in odd octants.
  assign oct    = angle[23:21];
  assign swap   = oct[1] ^ oct[0];
  assign cneg   = oct[2] ^ oct[1];
  assign sneg   = oct[2];
  assign r_fold = oct[0] ? (22'h20_0000 - {1'b0, angle[20:0]}) : {1'b0, angle[20:0]};
  assign cmag   = swap ? s : t;
  assign smag   = swap ? t : s;
  assign line_ext = {20'd0, line_counter};

  lpc_serial_unit #(
    .A_BITS (A_BITS)
  ) u_unit (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .opa (opa),
    .opb (opb),
    .sts (sts),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next  = state;
    issued_next = issued;
    ctl.start   = 1'b0;
    ctl.op      = OP_MUL;
    opa         = '0;
    opb         = '0;
    calc        = 1'b0;
    after       = state;
    unique case (state)
      S_IDLE: begin
        if (sample_valid && has_result) begin
          state_next = S_ANGLE;
        end
      end
      S_ANGLE: begin
        calc  = 1'b1;
        opa   = A_BITS'(angle_step);
        opb   = MUL_B_BITS'(step_r);
        after = S_XR;
      end
      S_XR: begin
        calc  = 1'b1;
        opa   = A_BITS'(TWO_PI_Q36);
        opb   = MUL_B_BITS'(r_fold);
        after = S_X2;
      end
      S_X2: begin
        calc  = 1'b1;
        opa   = A_BITS'(xr);
        opb   = MUL_B_BITS'(xr);
        after = S_SIN_MUL;
      end
      S_SIN_MUL: begin
        calc  = 1'b1;
        opa   = A_BITS'(t);
        opb   = MUL_B_BITS'(x2);
        after = S_SIN_DIV;
      end
      S_SIN_DIV: begin
        calc   = 1'b1;
        ctl.op = OP_DIV;
        opa    = A_BITS'(t);
        opb    = MUL_B_BITS'(sin_div(k));
        after  = (k == 3'(SIN_TERMS - 1)) ? S_SIN_END : S_SIN_MUL;
      end
      S_SIN_END: begin
        calc  = 1'b1;
        opa   = A_BITS'(t);
        opb   = MUL_B_BITS'(xr);
        after = S_COS_MUL;
      end
      S_COS_MUL: begin
        calc  = 1'b1;
        opa   = A_BITS'(t);
        opb   = MUL_B_BITS'(x2);
        after = S_COS_DIV;
      end
      S_COS_DIV: begin
        calc   = 1'b1;
        ctl.op = OP_DIV;
        opa    = A_BITS'(t);
        opb    = MUL_B_BITS'(cos_div(k));
        after  = (k == 3'(COS_TERMS - 1)) ? S_X : S_COS_MUL;
      end
      S_X: begin
        calc  = 1'b1;
        opa   = A_BITS'(cmag);
        opb   = MUL_B_BITS'(range_r);
        after = S_Y;
      end
      S_Y: begin
        calc  = 1'b1;
        opa   = A_BITS'(smag);
        opb   = MUL_B_BITS'(range_r);
        after = S_LINE;
      end
      S_LINE: begin
        calc  = 1'b1;
        opa   = A_BITS'(line_counter);
        opb   = MUL_B_BITS'(line_period);
        after = S_STEP;
      end
      S_STEP: begin
        calc  = 1'b1;
        opa   = A_BITS'(step_time);
        opb   = MUL_B_BITS'(step_r);
        after = S_TIME;
      end
      S_TIME: begin
        calc   = 1'b1;
        ctl.op = OP_DIV;
        opa    = A_BITS'(num);
        opb    = MUL_B_BITS'(TIME_DIVISOR);
        after  = S_FINISH;
      end
      S_FINISH: begin
        if (!point_valid || point_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Every arithmetic step issues once, then waits for the unit to finish.
    if (calc) begin
      if (!issued) begin
        ctl.start   = 1'b1;
        issued_next = 1'b1;
      end else if (sts.done) begin
        issued_next = 1'b0;
        state_next  = after;
      end
    end
  end

  // Registers, line and step bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RST;
      angle_step    <= ANGLE_STEP_RST;
      line_period   <= LINE_PERIOD_RST;
      step_time     <= STEP_TIME_RST;
      line_counter  <= '0;
      previous_step <= '0;
      step_counter  <= '0;
      seen_first    <= 1'b0;
      k             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MODE:        mode        <= cfg_data[0];
          CFG_ANGLE_STEP:  angle_step  <= cfg_data;
          CFG_LINE_PERIOD: line_period <= cfg_data[19:0];
          CFG_STEP_TIME:   step_time   <= cfg_data[19:0];
        endcase
      end
      if (accept) begin
        k          <= '0;
        seen_first <= 1'b1;
        if (!seen_first) begin
          line_counter <= '0;
        end else if (mode ? (step_index < previous_step) : line_start) begin
          line_counter <= line_counter + LINE_BITS'(1);
        end
        if (mode) begin
          previous_step <= step_index;
        end else begin
          step_counter <= step_sel + 16'd1;
        end
      end else if (op_done) begin
        if (state == S_SIN_DIV || state == S_COS_DIV) begin
          k <= k + 3'd1;
        end else if (state == S_SIN_END) begin
          k <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r  <= step_sel;
      range_r <= range_eff;
      inten_r <= mode ? intensity_in : 16'd0;
      t       <= Q30_ONE;
    end
    if (op_done) begin
      case (state)
        S_ANGLE:   angle <= res[23:0];
        S_XR:      xr    <= res[59:30] + {29'd0, res[29]};
        S_X2:      x2    <= res[59:30];
        S_SIN_MUL: t     <= res[60:30];
        S_SIN_DIV: t     <= Q30_ONE - res[30:0];
        S_SIN_END: begin
          s <= res[60:30];
          t <= Q30_ONE;
        end
        S_COS_MUL: t     <= res[60:30];
        S_COS_DIV: t     <= Q30_ONE - res[30:0];
        S_X:       xq    <= to_coord(res, cneg);
        S_Y:       yq    <= to_coord(res, sneg);
        S_LINE:    lp    <= res[47:0];
        S_STEP:    num   <= res[36:0] + 37'(TIME_ROUND);
        S_TIME:    timev <= lp + 48'(res[DIV_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Point channel output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (out_load) begin
      point_valid <= 1'b1;
    end else if (point_ready) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      x_q8          <= $signed(xq);
      y_q8          <= $signed(yq);
      angle_turns   <= angle;
      time_us       <= timev;
      line_number   <= line_ext[19:0];
      intensity_out <= inten_r;
    end
  end

  `LPC_ASSERT_IMP(a_unit_free_on_start, ctl.start, !sts.busy, "unit started while busy")
  `LPC_ASSERT_NXT(a_line_held, !(sample_valid && sample_ready), $stable(line_counter), "line counter moved without an item")
  `LPC_ASSERT_NXT(a_busy_after_point_item, sample_valid && sample_ready && has_result, !sample_ready, "ready stayed high for an item with a point")
  `LPC_ASSERT_IMP(a_point_from_finish, $rose(point_valid), $past(state == S_FINISH), "point appeared outside the last step")

endmodule
